[src/z80_flag_and_daa_unit_top_assert.svh]
// assertion macros shared by the flag and daa unit
`ifndef Z80_FLAG_AND_DAA_UNIT_TOP_ASSERT_SVH
`define Z80_FLAG_AND_DAA_UNIT_TOP_ASSERT_SVH

// cond in a cycle implies expr in the next cycle
`define Z80FD_ASSERT_NEXT(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("z80fd next-cycle check failed");

// cond implies expr in the same cycle
`define Z80FD_ASSERT_NOW(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("z80fd same-cycle check failed");

`endif

[src/z80fd_pkg.sv]
// types, codes and helpers for the z80 flag and daa unit
package z80fd_pkg;

   localparam logic [3:0] ACT_PARITY = 4'd0;
   localparam logic [3:0] ACT_DISP   = 4'd1;
   localparam logic [3:0] ACT_INC    = 4'd2;
   localparam logic [3:0] ACT_DEC    = 4'd3;
   localparam logic [3:0] ACT_AND    = 4'd4;
   localparam logic [3:0] ACT_OR_XOR = 4'd5;
   localparam logic [3:0] ACT_ADD    = 4'd6;
   localparam logic [3:0] ACT_SUB    = 4'd7;
   localparam logic [3:0] ACT_CP     = 4'd8;
   localparam logic [3:0] ACT_NEG    = 4'd9;
   localparam logic [3:0] ACT_DAA    = 4'd10;

   localparam logic [7:0] DISP_BIAS = 8'h80;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] value;
      logic       n_in;
      logic       c_in;
      logic       h_in;
   } req_type;

   typedef struct packed {
      logic [7:0] flag_byte;
      logic [7:0] value_out;
   } rsp_type;

   // z80 parity flag: set on an even number of ones
   function automatic logic even_parity(input logic [7:0] v);
      even_parity = ~(^v);
   endfunction

endpackage

[src/z80fd_flag_logic.sv]
// combinational flag and daa computation for one request
module z80fd_flag_logic (
   input  z80fd_pkg::req_type req,
   output z80fd_pkg::rsp_type rsp
);
   import z80fd_pkg::*;

   logic [7:0] v;
   logic [3:0] lo;
   logic [7:0] inc_r;
   logic [7:0] dec_r;
   logic [7:0] neg_r;
   logic       v_zero;
   logic       daa_lo_adj;
   logic       daa_hi_adj;
   logic [7:0] daa_add;
   logic [7:0] daa_r;
   logic       daa_h;
   logic [7:0] flags;
   logic [7:0] res;

   assign v      = req.value;
   assign lo     = v[3:0];
   assign inc_r  = v + 8'd1;
   assign dec_r  = v - 8'd1;
   assign neg_r  = 8'd0 - v;
   assign v_zero = (v == 8'h00);

   assign daa_lo_adj = req.h_in | (lo > 4'd9);
   assign daa_hi_adj = req.c_in | (v > 8'h99);

   always_comb begin
      daa_add = 8'h00;
      unique case ({daa_hi_adj, daa_lo_adj})
         2'b01:   daa_add = req.n_in ? 8'hFA : 8'h06;
         2'b10:   daa_add = req.n_in ? 8'hA0 : 8'h60;
         2'b11:   daa_add = req.n_in ? 8'h9A : 8'h66;
         default: daa_add = 8'h00;
      endcase
   end

   assign daa_r = v + daa_add;
   // half carry after the adjust depends on direction
   assign daa_h = req.n_in ? (req.h_in & (lo < 4'd6)) : (lo >= 4'hA);

   // flag order: s z y h x p n c
   always_comb begin
      flags = 8'h00;
      res   = v;
      unique case (req.action)
         ACT_PARITY: flags = {5'b0, even_parity(v), 2'b0};
         ACT_DISP:   res   = v ^ DISP_BIAS;
         ACT_INC:    flags = {inc_r[7], inc_r == 8'h00, 1'b0, lo == 4'hF, 1'b0,
                              v == 8'h7F, 2'b00};
         ACT_DEC:    flags = {dec_r[7], dec_r == 8'h00, 1'b0, lo == 4'h0, 1'b0,
                              v == 8'h80, 2'b10};
         ACT_AND:    flags = {v[7], v_zero, v[5], 1'b1, v[3], even_parity(v), 2'b00};
         ACT_OR_XOR: flags = {v[7], v_zero, v[5], 1'b0, v[3], even_parity(v), 2'b00};
         ACT_ADD:    flags = {v[7], v_zero, v[5], 1'b0, v[3], 3'b000};
         ACT_SUB:    flags = {v[7], v_zero, v[5], 1'b0, v[3], 3'b010};
         ACT_CP:     flags = {v[7], v_zero, 4'b0000, 2'b10};
         ACT_NEG:    flags = {neg_r[7], v_zero, neg_r[5], ~v_zero, neg_r[3],
                              v == 8'h80, 1'b1, ~v_zero};
         ACT_DAA: begin
            flags = {daa_r[7], daa_r == 8'h00, daa_r[5], daa_h, daa_r[3],
                     even_parity(daa_r), req.n_in, daa_hi_adj};
            res   = daa_r;
         end
         default: begin
            flags = 8'h00;
            res   = v;
         end
      endcase
   end

   assign rsp.flag_byte = flags;
   assign rsp.value_out = res;

endmodule

[src/z80_flag_and_daa_unit_top.sv]
// top level of the z80 flag and daa unit
// usage:
//   a request is taken at a rising edge with start high and busy low; busy
//   is never raised, so a request may be issued in every cycle
//   the request carries an action code, an operand byte and the incoming
//   n, c and h flags (the flags matter only for daa)
//   the request is captured in an input register, the flag logic runs in
//   one combinational pass, and the response lands in an output register
//   latency: the response is driven from the edge after the request edge,
//   on rsp_flag_byte and rsp_value_out with rsp_strobe high for one cycle,
//   and is taken at the second edge after the request edge
//   throughput: one request per cycle, set by the single pass through the
//   flag logic between the two registers
//   the receiver must take each response in its strobe cycle; there is no
//   back-pressure on the response side
//   reset clears both stage valid bits, so no response is produced from
//   a request in flight at reset
module z80_flag_and_daa_unit_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [3:0] req_action,
   input  logic [7:0] req_value,
   input  logic       req_n_in,
   input  logic       req_c_in,
   input  logic       req_h_in,
   output logic       rsp_strobe,
   output logic [7:0] rsp_flag_byte,
   output logic [7:0] rsp_value_out
);
   import z80fd_pkg::*;

   logic    stage_valid_ff;
   logic    stage_valid_in;
   req_type stage_req_ff;
   req_type stage_req_in;
   rsp_type calc_rsp;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type out_rsp_in;

   assign busy = 1'b0;

   assign stage_valid_in = start & ~busy;
   assign stage_req_in   = '{action: req_action, value: req_value, n_in: req_n_in,
                             c_in: req_c_in, h_in: req_h_in};

   z80fd_flag_logic u_flag_logic (
      .req (stage_req_ff),
      .rsp (calc_rsp)
   );

   assign out_valid_in = stage_valid_ff;
   assign out_rsp_in   = calc_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      stage_req_ff <= stage_req_in;
      out_rsp_ff   <= out_rsp_in;
   end

   assign rsp_strobe    = out_valid_ff;
   assign rsp_flag_byte = out_rsp_ff.flag_byte;
   assign rsp_value_out = out_rsp_ff.value_out;

`include "z80_flag_and_daa_unit_top_assert.svh"

   `Z80FD_ASSERT_NEXT(a_stage_to_out, stage_valid_ff, rsp_strobe)
   `Z80FD_ASSERT_NEXT(a_out_from_stage, !stage_valid_ff, !rsp_strobe)
   `Z80FD_ASSERT_NEXT(a_disp_result,
      stage_valid_ff && stage_req_ff.action == ACT_DISP,
      rsp_flag_byte == 8'h00 && rsp_value_out == ($past(stage_req_ff.value) ^ DISP_BIAS))
   `Z80FD_ASSERT_NOW(a_daa_only_adjusts,
      stage_valid_ff && stage_req_ff.action != ACT_DAA && stage_req_ff.action != ACT_DISP,
      calc_rsp.value_out == stage_req_ff.value)

endmodule

[tb/tb_z80_flag_and_daa_unit_top.sv]
// self-checking testbench for the z80 flag and daa unit top level
module tb_z80_flag_and_daa_unit_top;
   timeunit 1ns;
   timeprecision 1ps;

   import z80fd_pkg::*;

   localparam logic [7:0] FLAG_S = 8'h80;
   localparam logic [7:0] FLAG_Z = 8'h40;
   localparam logic [7:0] FLAG_Y = 8'h20;
   localparam logic [7:0] FLAG_H = 8'h10;
   localparam logic [7:0] FLAG_X = 8'h08;
   localparam logic [7:0] FLAG_P = 8'h04;
   localparam logic [7:0] FLAG_N = 8'h02;
   localparam logic [7:0] FLAG_C = 8'h01;

   localparam int RANDOM_LOOKUPS = 1450;
   localparam int IDLE_PERCENT   = 36;
   localparam int MAX_PRINTED    = 40;

   typedef struct {
      req_type req;
      bit      drain;   // hold off until every response is back
      bit      no_gap;
   } lookup_req;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [3:0] req_action;
   logic [7:0] req_value;
   logic       req_n_in;
   logic       req_c_in;
   logic       req_h_in;
   logic       rsp_strobe;
   logic [7:0] rsp_flag_byte;
   logic [7:0] rsp_value_out;

   lookup_req lookup_reqs[$];
   rsp_type   flag_results_due[$];
   logic      req_taken;
   int        mismatch_count;

   z80_flag_and_daa_unit_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_n_in     (req_n_in),
      .req_c_in     (req_c_in),
      .req_h_in     (req_h_in),
      .rsp_strobe   (rsp_strobe),
      .rsp_flag_byte(rsp_flag_byte),
      .rsp_value_out(rsp_value_out)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] sign_zero_xy(input logic [7:0] v);
      return (v & (FLAG_S | FLAG_Y | FLAG_X)) | ((v == 8'h00) ? FLAG_Z : 8'h00);
   endfunction

   function automatic logic [7:0] parity_bit(input logic [7:0] v);
      return (^v) ? 8'h00 : FLAG_P;
   endfunction

   function automatic rsp_type z80_flag_result(input req_type r);
      rsp_type    res;
      logic [7:0] f;
      logic [7:0] t8;
      logic [7:0] addend;
      logic       low_adj;
      logic       high_adj;
      logic       half;
      f = 8'h00;
      res.value_out = r.value;
      case (r.action)
         ACT_PARITY: f = parity_bit(r.value);
         ACT_DISP:   res.value_out = r.value ^ DISP_BIAS;
         ACT_INC: begin
            t8 = r.value + 8'd1;
            f = (t8 & FLAG_S) | ((t8 == 8'h00) ? FLAG_Z : 8'h00);
            if (r.value[3:0] == 4'hF) f |= FLAG_H;
            if (r.value == 8'h7F) f |= FLAG_P;
         end
         ACT_DEC: begin
            t8 = r.value - 8'd1;
            f = FLAG_N | (t8 & FLAG_S) | ((t8 == 8'h00) ? FLAG_Z : 8'h00);
            if (r.value[3:0] == 4'h0) f |= FLAG_H;
            if (r.value == 8'h80) f |= FLAG_P;
         end
         ACT_AND:    f = FLAG_H | parity_bit(r.value) | sign_zero_xy(r.value);
         ACT_OR_XOR: f = parity_bit(r.value) | sign_zero_xy(r.value);
         ACT_ADD:    f = sign_zero_xy(r.value);
         ACT_SUB:    f = FLAG_N | sign_zero_xy(r.value);
         ACT_CP:     f = FLAG_N | (r.value & FLAG_S) | ((r.value == 8'h00) ? FLAG_Z : 8'h00);
         ACT_NEG: begin
            t8 = 8'h00 - r.value;
            f = FLAG_N | (t8 & (FLAG_S | FLAG_X | FLAG_Y));
            f |= (r.value == 8'h00) ? FLAG_Z : (FLAG_H | FLAG_C);
            if (r.value == 8'h80) f |= FLAG_P;
         end
         ACT_DAA: begin
            low_adj  = r.h_in || (r.value[3:0] > 4'd9);
            high_adj = r.c_in || (r.value > 8'h99);
            if (r.n_in) half = r.h_in && (r.value[3:0] < 4'd6);
            else half = r.value[3:0] >= 4'hA;
            case ({high_adj, low_adj})
               2'b01:   addend = r.n_in ? 8'hFA : 8'h06;
               2'b10:   addend = r.n_in ? 8'hA0 : 8'h60;
               2'b11:   addend = r.n_in ? 8'h9A : 8'h66;
               default: addend = 8'h00;
            endcase
            t8 = r.value + addend;
            res.value_out = t8;
            f = sign_zero_xy(t8) | parity_bit(t8);
            if (r.n_in) f |= FLAG_N;
            if (r.c_in || high_adj) f |= FLAG_C;
            if (half) f |= FLAG_H;
         end
         default: f = 8'h00;
      endcase
      res.flag_byte = f;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at %0t ns: %s got %02h want %02h", $time, what, got, want);
   endtask

   task automatic add_lookup(input logic [3:0] action, input logic [7:0] value,
                             input bit n, input bit c, input bit h,
                             input bit drain, input bit no_gap);
      lookup_req item;
      item.req.action = action;
      item.req.value  = value;
      item.req.n_in   = n;
      item.req.c_in   = c;
      item.req.h_in   = h;
      item.drain      = drain;
      item.no_gap     = no_gap;
      lookup_reqs.push_back(item);
   endtask

   // driver: change inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // request still waiting, hold it
      end else if (lookup_reqs.size() == 0) begin
         start <= 1'b0;
      end else if (lookup_reqs[0].drain && flag_results_due.size() != 0) begin
         start <= 1'b0;
      end else if (!lookup_reqs[0].no_gap && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
      end else begin
         start      <= 1'b1;
         req_action <= lookup_reqs[0].req.action;
         req_value  <= lookup_reqs[0].req.value;
         req_n_in   <= lookup_reqs[0].req.n_in;
         req_c_in   <= lookup_reqs[0].req.c_in;
         req_h_in   <= lookup_reqs[0].req.h_in;
         void'(lookup_reqs.pop_front());
      end
   end

   // monitor: check responses and record accepted requests on the rising edge
   always @(posedge clock) begin
      rsp_type want;
      req_type seen;
      if (!reset && rsp_strobe === 1'b1) begin
         if (flag_results_due.size() == 0) begin
            report_mismatch("response with nothing outstanding, flag_byte",
                            rsp_flag_byte, 8'h00);
         end else begin
            want = flag_results_due.pop_front();
            if (rsp_flag_byte !== want.flag_byte)
               report_mismatch("flag_byte", rsp_flag_byte, want.flag_byte);
            if (rsp_value_out !== want.value_out)
               report_mismatch("value_out", rsp_value_out, want.value_out);
         end
      end
      if (!reset && start && busy === 1'b0) begin
         seen.action = req_action;
         seen.value  = req_value;
         seen.n_in   = req_n_in;
         seen.c_in   = req_c_in;
         seen.h_in   = req_h_in;
         flag_results_due.push_back(z80_flag_result(seen));
      end
      req_taken <= !reset && start && (busy === 1'b0);
   end

   initial begin
      logic [7:0] corner_vals [0:10];
      logic [3:0] action;
      logic [7:0] value;
      corner_vals = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h81,
                      8'h99, 8'h9A, 8'hF0, 8'hFF};
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = 4'd0;
      req_value      = 8'h00;
      req_n_in       = 1'b0;
      req_c_in       = 1'b0;
      req_h_in       = 1'b0;
      req_taken      = 1'b0;
      mismatch_count = 0;

      // directed: field extremes, each action and the corner cases
      add_lookup(ACT_PARITY, 8'h00, 0, 0, 0, 0, 0);
      add_lookup(ACT_PARITY, 8'h01, 1, 1, 1, 0, 0);
      add_lookup(ACT_DISP,   8'h00, 0, 0, 0, 0, 0);
      add_lookup(ACT_DISP,   8'hFF, 1, 1, 1, 0, 0);
      add_lookup(ACT_INC,    8'h7F, 0, 0, 0, 0, 0);  // overflow into sign
      add_lookup(ACT_INC,    8'hFF, 0, 0, 0, 0, 0);
      add_lookup(ACT_INC,    8'h0F, 0, 0, 0, 0, 0);
      add_lookup(ACT_DEC,    8'h80, 0, 0, 0, 0, 0);  // overflow out of sign
      add_lookup(ACT_DEC,    8'h01, 0, 0, 0, 0, 0);
      add_lookup(ACT_DEC,    8'h00, 0, 0, 0, 0, 0);
      add_lookup(ACT_AND,    8'h00, 0, 0, 0, 0, 0);
      add_lookup(ACT_OR_XOR, 8'h80, 0, 0, 0, 0, 0);
      add_lookup(ACT_ADD,    8'hFF, 0, 0, 0, 0, 0);
      add_lookup(ACT_SUB,    8'h28, 0, 0, 0, 0, 0);
      add_lookup(ACT_CP,     8'h00, 0, 0, 0, 0, 0);
      add_lookup(ACT_CP,     8'hA8, 0, 0, 0, 0, 0);
      add_lookup(ACT_NEG,    8'h00, 0, 0, 0, 0, 0);
      add_lookup(ACT_NEG,    8'h80, 0, 0, 0, 0, 0);
      add_lookup(ACT_NEG,    8'h01, 0, 0, 0, 0, 0);  // sign from negated byte
      add_lookup(ACT_DAA,    8'h9A, 0, 0, 0, 0, 0);
      add_lookup(ACT_DAA,    8'h00, 1, 1, 1, 0, 0);
      add_lookup(ACT_DAA,    8'h05, 1, 0, 1, 0, 0);
      add_lookup(ACT_DAA,    8'hFF, 0, 1, 1, 0, 0);
      add_lookup(ACT_DAA,    8'h99, 1, 0, 0, 0, 0);
      add_lookup(4'd15,      8'hAA, 0, 0, 0, 0, 0);  // unused code

      for (int i = 0; i < RANDOM_LOOKUPS; i++) begin
         if ($urandom_range(19) == 0) action = 4'($urandom_range(15, 11));
         else action = 4'($urandom_range(10, 0));
         if ($urandom_range(7) == 0) value = corner_vals[$urandom_range(10)];
         else value = 8'($urandom);
         add_lookup(action, value, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), (i == 0 || i == 725 || i == 1100),
                    (i >= 500 && i < 700));
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (lookup_reqs.size() != 0 || start || flag_results_due.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS z80_flag_and_daa_unit_top");
      end else begin
         $display("FAIL z80_flag_and_daa_unit_top");
      end
      $finish;
   end

   initial begin
      #1200000;
      $display("FAIL z80_flag_and_daa_unit_top");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/z80fd_pkg.sv
src/z80fd_flag_logic.sv
src/z80_flag_and_daa_unit_top.sv
tb/tb_z80_flag_and_daa_unit_top.sv
